// ----- design/mvd_pkg.sv -----
// Package for the MAVLink v2 deframer: phase codes, message constants and lookups.
`timescale 1ns / 1ps
`default_nettype none
package mvd_pkg;

  localparam int unsigned SIGNATURE_BYTES_DEF = 13;

  localparam logic [7:0]  START_BYTE = 8'hFD;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  // header byte positions (incompat flags is position 1)
  localparam logic [3:0] HDR_INCOMPAT = 4'd1;
  localparam logic [3:0] HDR_SEQ      = 4'd3;
  localparam logic [3:0] HDR_SYSID    = 4'd4;
  localparam logic [3:0] HDR_COMPID   = 4'd5;
  localparam logic [3:0] HDR_MSGID0   = 4'd6;
  localparam logic [3:0] HDR_MSGID1   = 4'd7;
  localparam logic [3:0] HDR_MSGID2   = 4'd8;

  localparam logic [23:0] MSG_HEARTBEAT   = 24'd0;
  localparam logic [23:0] MSG_SYS_STATUS  = 24'd1;
  localparam logic [23:0] MSG_RC_CHANNELS = 24'd65;
  localparam logic [23:0] MSG_RC_OVERRIDE = 24'd70;
  localparam logic [23:0] MSG_BATTERY     = 24'd147;

  localparam logic [7:0] EXTRA_HEARTBEAT   = 8'd50;
  localparam logic [7:0] EXTRA_SYS_STATUS  = 8'd124;
  localparam logic [7:0] EXTRA_RC_CHANNELS = 8'd118;
  localparam logic [7:0] EXTRA_RC_OVERRIDE = 8'd124;
  localparam logic [7:0] EXTRA_BATTERY     = 8'd154;

  localparam logic [1:0] STAT_GOOD   = 2'd0;
  localparam logic [1:0] STAT_BADCRC = 2'd1;
  localparam logic [1:0] STAT_SIGNED = 2'd2;

  localparam logic [2:0] CLS_HEARTBEAT = 3'd0;
  localparam logic [2:0] CLS_RC_CHAN   = 3'd1;
  localparam logic [2:0] CLS_RC_OVR    = 3'd2;
  localparam logic [2:0] CLS_STATUS    = 3'd3;
  localparam logic [2:0] CLS_OTHER     = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  localparam int unsigned OUT_DATA_W = 112;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_HDR,
    PH_PAY,
    PH_CRC,
    PH_SIG
  } phase_t;

  function automatic logic [7:0] extra_for(input logic [23:0] id);
    logic [7:0] e;
    e = 8'd0;
    if (id == MSG_HEARTBEAT)   e = EXTRA_HEARTBEAT;
    if (id == MSG_SYS_STATUS)  e = EXTRA_SYS_STATUS;
    if (id == MSG_RC_CHANNELS) e = EXTRA_RC_CHANNELS;
    if (id == MSG_RC_OVERRIDE) e = EXTRA_RC_OVERRIDE;
    if (id == MSG_BATTERY)     e = EXTRA_BATTERY;
    return e;
  endfunction

  function automatic logic [2:0] class_for(input logic [23:0] id);
    logic [2:0] c;
    c = CLS_OTHER;
    if (id == MSG_HEARTBEAT)   c = CLS_HEARTBEAT;
    if (id == MSG_RC_CHANNELS) c = CLS_RC_CHAN;
    if (id == MSG_RC_OVERRIDE) c = CLS_RC_OVR;
    if (id == MSG_SYS_STATUS || id == MSG_BATTERY) c = CLS_STATUS;
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- design/mvd_crc16.sv -----
// One-byte step of the X.25 / MCRF4XX CRC-16.
`timescale 1ns / 1ps
`default_nettype none
module mvd_crc16 (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data,
  output logic      [15:0] crc_out
);

  logic [7:0] t0;
  logic [7:0] t1;

  always_comb begin
    t0 = data ^ crc_in[7:0];
    t1 = t0 ^ {t0[3:0], 4'b0000};
    crc_out = {8'h00, crc_in[15:8]} ^ {t1, 8'h00} ^ {5'b00000, t1, 3'b000}
            ^ {12'h000, t1[7:4]};
  end

endmodule
`default_nettype wire

// ----- design/mavlink_v2_frame_deframer.sv -----
// MAVLink v2 deframer: start hunt, header capture, running CRC, payload forward, frame report.
//
// Usage:
//   in_*  : one link byte per word in in_tdata[7:0].
//   out_* : one word per payload byte (out_tuser = 0) and one end-of-frame report
//           (out_tuser = 1) after the second CRC byte; header bytes, the first CRC
//           byte and signature bytes give no word.
//   Every accepted byte is processed in the cycle it is taken and any result lands
//   in the output register at that edge; throughput is one byte per cycle while
//   the output is not stalled, set by the combinational CRC step and header capture.
//   The CRC of the frame is finished (message seed byte folded in) on the first CRC
//   byte, so the second CRC byte compares (unsigned frames only), counts and reports.
//   Reset (rst_n low, synchronous) returns to start-byte hunt with the CRC at
//   0xFFFF, the mismatch count at zero and the output register empty.
//   If the receiver stalls with a word held, in_tready drops only while that word
//   waits; it rises again in the cycle out_tready takes the word.
//   Signed frames are reported with signed status and their signature bytes are
//   swallowed before hunting resumes.
`timescale 1ns / 1ps
`default_nettype none
module mavlink_v2_frame_deframer #(
  parameter int unsigned SIGNATURE_BYTES = mvd_pkg::SIGNATURE_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_byte
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [7:0] payload_byte, [15:8] byte_index, [17:16] frame_status, [20:18] frame_class,
  // [44:21] message_number, [52:45] sender_system, [60:53] sender_component,
  // [68:61] sequence_value, [76:69] frame_payload_length, [108:77] crc_failures,
  // [111:109] zero
  output logic [mvd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic              out_tuser   // [0] result_kind
);

  localparam int unsigned SigW = $clog2(SIGNATURE_BYTES + 1);

  mvd_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  pay_cnt_r, pay_cnt_nxt;
  logic        signed_r, signed_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [7:0]  sysid_r, sysid_nxt;
  logic [7:0]  compid_r, compid_nxt;
  logic [23:0] msgid_r, msgid_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic        crc_seen_r, crc_seen_nxt;
  logic [SigW-1:0] sig_cnt_r, sig_cnt_nxt;
  logic [31:0] crc_err_r, crc_err_nxt;

  logic        out_tvalid_r, out_tvalid_nxt;
  logic [mvd_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic        out_tuser_r, out_tuser_nxt;

  logic        in_fire;
  logic [7:0]  b;
  logic [7:0]  crc_feed_byte;
  logic [15:0] crc_step;
  logic        emit;
  logic [1:0]  status;

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign b         = in_tdata;

  // in the CRC phase the unit folds in the message seed byte instead of the link byte
  assign crc_feed_byte = (phase_r == mvd_pkg::PH_CRC) ? mvd_pkg::extra_for(msgid_r) : b;

  mvd_crc16 u_crc (
    .crc_in  (crc_r),
    .data    (crc_feed_byte),
    .crc_out (crc_step)
  );

  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    len_nxt      = len_r;
    pay_cnt_nxt  = pay_cnt_r;
    signed_nxt   = signed_r;
    seq_nxt      = seq_r;
    sysid_nxt    = sysid_r;
    compid_nxt   = compid_r;
    msgid_nxt    = msgid_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    crc_seen_nxt = crc_seen_r;
    sig_cnt_nxt  = sig_cnt_r;
    crc_err_nxt  = crc_err_r;
    emit         = 1'b0;
    status       = mvd_pkg::STAT_GOOD;
    out_tuser_nxt = mvd_pkg::KIND_PAYLOAD;
    out_tdata_nxt = '0;

    if (in_fire) begin
      unique case (phase_r)
        mvd_pkg::PH_HUNT: begin
          if (b == mvd_pkg::START_BYTE) begin
            phase_nxt = mvd_pkg::PH_LEN;
            crc_nxt   = mvd_pkg::CRC_INIT;
          end
        end
        mvd_pkg::PH_LEN: begin
          len_nxt     = b;
          crc_nxt     = crc_step;
          hdr_cnt_nxt = 4'd1;
          phase_nxt   = mvd_pkg::PH_HDR;
        end
        mvd_pkg::PH_HDR: begin
          crc_nxt     = crc_step;
          hdr_cnt_nxt = hdr_cnt_r + 4'd1;
          unique case (hdr_cnt_r)
            mvd_pkg::HDR_INCOMPAT: signed_nxt = b[0];
            mvd_pkg::HDR_SEQ:      seq_nxt    = b;
            mvd_pkg::HDR_SYSID:    sysid_nxt  = b;
            mvd_pkg::HDR_COMPID:   compid_nxt = b;
            mvd_pkg::HDR_MSGID0:   msgid_nxt  = {16'h0000, b};
            mvd_pkg::HDR_MSGID1:   msgid_nxt[15:8]  = b;
            mvd_pkg::HDR_MSGID2: begin
              msgid_nxt[23:16] = b;
              pay_cnt_nxt  = 8'd0;
              crc_seen_nxt = 1'b0;
              phase_nxt    = (len_r == 8'd0) ? mvd_pkg::PH_CRC : mvd_pkg::PH_PAY;
            end
            default: ;
          endcase
        end
        mvd_pkg::PH_PAY: begin
          crc_nxt = crc_step;
          emit    = 1'b1;
          out_tdata_nxt[7:0]    = b;
          out_tdata_nxt[15:8]   = pay_cnt_r;
          out_tdata_nxt[108:77] = crc_err_r;
          if ({1'b0, pay_cnt_r} + 9'd1 >= {1'b0, len_r}) begin
            crc_seen_nxt = 1'b0;
            phase_nxt    = mvd_pkg::PH_CRC;
          end
          pay_cnt_nxt = pay_cnt_r + 8'd1;
        end
        mvd_pkg::PH_CRC: begin
          if (!crc_seen_r) begin
            crc_lo_nxt   = b;
            crc_seen_nxt = 1'b1;
            crc_nxt      = crc_step;   // finished frame CRC
          end else begin
            crc_seen_nxt = 1'b0;
            emit         = 1'b1;
            if (signed_r) begin
              status      = mvd_pkg::STAT_SIGNED;
              sig_cnt_nxt = '0;
              phase_nxt   = mvd_pkg::PH_SIG;
            end else begin
              phase_nxt = mvd_pkg::PH_HUNT;
              if (crc_r != {b, crc_lo_r}) begin
                crc_err_nxt = crc_err_r + 32'd1;
                status      = mvd_pkg::STAT_BADCRC;
              end
            end
            out_tuser_nxt          = mvd_pkg::KIND_REPORT;
            out_tdata_nxt[17:16]   = status;
            out_tdata_nxt[20:18]   = mvd_pkg::class_for(msgid_r);
            out_tdata_nxt[44:21]   = msgid_r;
            out_tdata_nxt[52:45]   = sysid_r;
            out_tdata_nxt[60:53]   = compid_r;
            out_tdata_nxt[68:61]   = seq_r;
            out_tdata_nxt[76:69]   = len_r;
            out_tdata_nxt[108:77]  = crc_err_nxt;
          end
        end
        mvd_pkg::PH_SIG: begin
          sig_cnt_nxt = sig_cnt_r + 1'b1;
          if (sig_cnt_nxt == SigW'(SIGNATURE_BYTES)) phase_nxt = mvd_pkg::PH_HUNT;
        end
        default: phase_nxt = mvd_pkg::PH_HUNT;
      endcase
    end

    if (emit)            out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
    else                 out_tvalid_nxt = out_tvalid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= mvd_pkg::PH_HUNT;
      hdr_cnt_r    <= '0;
      len_r        <= '0;
      pay_cnt_r    <= '0;
      signed_r     <= 1'b0;
      seq_r        <= '0;
      sysid_r      <= '0;
      compid_r     <= '0;
      msgid_r      <= '0;
      crc_r        <= mvd_pkg::CRC_INIT;
      crc_lo_r     <= '0;
      crc_seen_r   <= 1'b0;
      sig_cnt_r    <= '0;
      crc_err_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      len_r        <= len_nxt;
      pay_cnt_r    <= pay_cnt_nxt;
      signed_r     <= signed_nxt;
      seq_r        <= seq_nxt;
      sysid_r      <= sysid_nxt;
      compid_r     <= compid_nxt;
      msgid_r      <= msgid_nxt;
      crc_r        <= crc_nxt;
      crc_lo_r     <= crc_lo_nxt;
      crc_seen_r   <= crc_seen_nxt;
      sig_cnt_r    <= sig_cnt_nxt;
      crc_err_r    <= crc_err_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // output payload register, no reset needed
  always_ff @(posedge clk) begin
    if (emit) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  // a payload byte always produces a payload word in the next cycle
  a_pay_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == mvd_pkg::PH_PAY) |=> (out_tvalid && out_tuser == mvd_pkg::KIND_PAYLOAD))
    else $error("payload byte did not produce a word");

  // mismatch count only ever steps by one
  a_err_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && crc_err_r != $past(crc_err_r)) |-> (crc_err_r == $past(crc_err_r) + 32'd1))
    else $error("crc failure count jumped");

  // input backpressure only while a word waits on a stalled output
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  // reports leave the header path back in hunt or signature phase
  a_report_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == mvd_pkg::PH_CRC && crc_seen_r)
      |=> (phase_r == mvd_pkg::PH_HUNT || phase_r == mvd_pkg::PH_SIG))
    else $error("frame report left an unexpected phase");
`endif

endmodule
`default_nettype wire
